// ===== rtl/rbts_pkg.sv =====
package rbts_pkg;

	localparam logic [31:0] SEED_RESET   = 32'hABCD1234;
	localparam int          XS_SHIFT_A   = 13;
	localparam int          XS_SHIFT_B   = 17;
	localparam int          XS_SHIFT_C   = 5;
	localparam logic [31:0] START_DELAY  = 32'd100;
	localparam logic [31:0] BEACON_FIRST = 32'd5000;
	localparam logic [31:0] UPLINK_FIRST = 32'd3000;
	localparam logic [31:0] HS_STAGGER   = 32'd6000;
	localparam int          MESH_LEN     = 20;
	localparam int          HS_LEN       = 25;
	localparam logic [3:0]  MESH_SF      = 4'd11;
	localparam logic [31:0] PCT_LIMIT    = 32'd30;
	localparam int          REM_W        = 16;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_POLL  = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;

	localparam logic [1:0] MODE_MESH    = 2'd0;
	localparam logic [1:0] MODE_HOTSPOT = 2'd1;
	localparam logic [1:0] MODE_UPLINK  = 2'd2;

	localparam logic [1:0] KIND_MESH    = 2'd0;
	localparam logic [1:0] KIND_RELAY   = 2'd1;
	localparam logic [1:0] KIND_HOTSPOT = 2'd2;
	localparam logic [1:0] KIND_UPLINK  = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_START,
		OP_STOP,
		OP_POLL_HS,
		OP_RAND,
		OP_DRAW_NEXT,
		OP_FILL,
		OP_LD_FILL_MESH,
		OP_LD_FILL_VAL,
		OP_ST_HS_START,
		OP_ST_CH,
		OP_ST_SF,
		OP_ST_LEN,
		OP_EMIT,
		OP_ST_BURSTN,
		OP_ST_BURSTD,
		OP_ST_BEACON,
		OP_ST_HS_DL,
		OP_ST_UL_DL,
		OP_HS_NEXT
	} op_t;

	typedef enum logic [3:0] {
		R_HS_START,
		R_PCT,
		R_BURSTN,
		R_BURSTD,
		R_BEACON,
		R_WIDE,
		R_SF_HS,
		R_HS_DL,
		R_REG,
		R_SF_UL,
		R_LEN,
		R_UL_DL
	} rng_t;

	typedef struct packed {
		op_t        op;
		rng_t       sel;
		logic [1:0] kind;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       running;
		logic [1:0] mode;
		logic [1:0] cfg_mode;
		logic       burst_active;
		logic       burst_left_zero;
		logic       due_beacon;
		logic       due_burst;
		logic       due_uplink;
		logic       hs_cur_due;
		logic       hs_idx_last;
		logic       mod_busy;
		logic       fill_zero;
		logic       val_lt30;
		logic       out_free;
	} stat_t;

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << XS_SHIFT_A);
		y = y ^ (y >> XS_SHIFT_B);
		y = y ^ (y << XS_SHIFT_C);
		return y;
	endfunction

	function automatic logic [31:0] rng_lo(input rng_t sel);
		logic [31:0] lo;
		unique case (sel)
			R_HS_START: lo = 32'd1000;
			R_BURSTN:   lo = 32'd3;
			R_BURSTD:   lo = 32'd300;
			R_BEACON:   lo = 32'd60000;
			R_SF_HS:    lo = 32'd8;
			R_HS_DL:    lo = 32'd25000;
			R_SF_UL:    lo = 32'd7;
			R_LEN:      lo = 32'd15;
			R_UL_DL:    lo = 32'd50000;
			default:    lo = 32'd0;
		endcase
		return lo;
	endfunction

endpackage

// ===== rtl/rbts_rem.sv =====
module rbts_rem (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [31:0]              dividend,
	input  logic [rbts_pkg::REM_W-1:0] divisor,
	output logic [rbts_pkg::REM_W-1:0] rem,
	output logic                     busy
);
	import rbts_pkg::*;

	logic [31:0]      dvd_q;
	logic [REM_W-1:0] dvs_q;
	logic [REM_W-1:0] rem_q;
	logic [2:0]       cnt_q;
	logic             busy_q;
	logic [REM_W:0]   r;

	always_comb begin
		r = {1'b0, rem_q};
		for (int k = 0; k < 4; k++) begin
			r = {r[REM_W-1:0], dvd_q[31-k]};
			if (r >= {1'b0, dvs_q}) begin
				r = r - {1'b0, dvs_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 3'd1;
			if (cnt_q == 3'd7) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 4;
			rem_q <= r[REM_W-1:0];
		end
	end

	assign rem  = rem_q;
	assign busy = busy_q;

endmodule

// ===== rtl/rbts_ctrl.sv =====
module rbts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rbts_pkg::stat_t st,
	output rbts_pkg::cmd_t  cmd
);
	import rbts_pkg::*;

	typedef enum logic [16:0] {
		S_IDLE         = 17'b1 << 0,
		S_DISPATCH     = 17'b1 << 1,
		S_HS_INIT      = 17'b1 << 2,
		S_HS_INIT_DRAW = 17'b1 << 3,
		S_HS_CHECK     = 17'b1 << 4,
		S_CH           = 17'b1 << 5,
		S_SF           = 17'b1 << 6,
		S_LEN_FILL     = 17'b1 << 7,
		S_FILL         = 17'b1 << 8,
		S_LEN          = 17'b1 << 9,
		S_EMIT         = 17'b1 << 10,
		S_PCT          = 17'b1 << 11,
		S_BURSTN       = 17'b1 << 12,
		S_BURSTD       = 17'b1 << 13,
		S_BEACON       = 17'b1 << 14,
		S_HS_DL        = 17'b1 << 15,
		S_UL_DL        = 17'b1 << 16
	} state_t;

	state_t     state_q, state_d;
	logic       issued_q, issued_d;
	logic [1:0] kind_q, kind_d;
	logic       wait_done;

	assign in_ready  = (state_q == S_IDLE);
	assign wait_done = issued_q && !st.mod_busy;

	always_comb begin
		state_d  = state_q;
		issued_d = issued_q;
		kind_d   = kind_q;
		cmd.op   = OP_NONE;
		cmd.sel  = R_PCT;
		cmd.kind = kind_q;
		if (!issued_q) begin
			unique case (state_q)
				S_HS_INIT, S_CH, S_SF, S_LEN_FILL, S_LEN, S_PCT, S_BURSTN, S_BURSTD,
				S_BEACON, S_HS_DL, S_UL_DL: issued_d = 1'b1;
				default: issued_d = 1'b0;
			endcase
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_IDLE;
				priority if (st.func == FUNC_START) begin
					cmd.op = OP_START;
					if (st.cfg_mode == MODE_HOTSPOT) begin
						state_d = S_HS_INIT;
					end
				end else if (st.func == FUNC_STOP) begin
					cmd.op = OP_STOP;
				end else if (st.func == FUNC_POLL && st.running) begin
					priority if (st.mode == MODE_MESH) begin
						if (st.burst_active) begin
							if (st.due_burst && !st.burst_left_zero) begin
								cmd.op  = OP_LD_FILL_MESH;
								kind_d  = KIND_RELAY;
								state_d = S_FILL;
							end
						end else if (st.due_beacon) begin
							cmd.op  = OP_LD_FILL_MESH;
							kind_d  = KIND_MESH;
							state_d = S_FILL;
						end
					end else if (st.mode == MODE_HOTSPOT) begin
						cmd.op  = OP_POLL_HS;
						kind_d  = KIND_HOTSPOT;
						state_d = S_HS_CHECK;
					end else if (st.mode == MODE_UPLINK) begin
						if (st.due_uplink) begin
							kind_d  = KIND_UPLINK;
							state_d = S_CH;
						end
					end else begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_IDLE;
				end
			end
			S_HS_INIT: begin
				cmd.sel = R_HS_START;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_HS_START;
					issued_d = 1'b0;
					state_d  = S_HS_INIT_DRAW;
				end
			end
			S_HS_INIT_DRAW: begin
				cmd.op  = OP_DRAW_NEXT;
				state_d = st.hs_idx_last ? S_IDLE : S_HS_INIT;
			end
			S_HS_CHECK: begin
				priority if (st.hs_cur_due) begin
					state_d = S_CH;
				end else if (st.hs_idx_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = OP_HS_NEXT;
				end
			end
			S_CH: begin
				cmd.sel = (kind_q == KIND_HOTSPOT) ? R_WIDE : R_REG;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_CH;
					issued_d = 1'b0;
					state_d  = S_SF;
				end
			end
			S_SF: begin
				cmd.sel = (kind_q == KIND_HOTSPOT) ? R_SF_HS : R_SF_UL;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_SF;
					issued_d = 1'b0;
					state_d  = (kind_q == KIND_HOTSPOT) ? S_FILL : S_LEN_FILL;
				end
			end
			S_LEN_FILL: begin
				cmd.sel = R_LEN;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_LD_FILL_VAL;
					issued_d = 1'b0;
					state_d  = S_FILL;
				end
			end
			S_FILL: begin
				if (st.fill_zero) begin
					state_d = (kind_q == KIND_UPLINK) ? S_LEN : S_EMIT;
				end else begin
					cmd.op = OP_FILL;
				end
			end
			S_LEN: begin
				cmd.sel = R_LEN;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_LEN;
					issued_d = 1'b0;
					state_d  = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.op = OP_EMIT;
					unique case (kind_q)
						KIND_MESH:    state_d = S_PCT;
						KIND_RELAY:   state_d = S_BURSTD;
						KIND_HOTSPOT: state_d = S_HS_DL;
						default:      state_d = S_UL_DL;
					endcase
				end
			end
			S_PCT: begin
				cmd.sel = R_PCT;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					issued_d = 1'b0;
					state_d  = st.val_lt30 ? S_BURSTN : S_BEACON;
				end
			end
			S_BURSTN: begin
				cmd.sel = R_BURSTN;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_BURSTN;
					issued_d = 1'b0;
					state_d  = S_BURSTD;
				end
			end
			S_BURSTD: begin
				cmd.sel = R_BURSTD;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_BURSTD;
					issued_d = 1'b0;
					state_d  = st.burst_left_zero ? S_BEACON : S_IDLE;
				end
			end
			S_BEACON: begin
				cmd.sel = R_BEACON;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_BEACON;
					issued_d = 1'b0;
					state_d  = S_IDLE;
				end
			end
			S_HS_DL: begin
				cmd.sel = R_HS_DL;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_HS_DL;
					issued_d = 1'b0;
					state_d  = st.hs_idx_last ? S_IDLE : S_HS_CHECK;
				end
			end
			S_UL_DL: begin
				cmd.sel = R_UL_DL;
				if (!issued_q) begin
					cmd.op = OP_RAND;
				end else if (wait_done) begin
					cmd.op   = OP_ST_UL_DL;
					issued_d = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d  = S_IDLE;
				issued_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			kind_q   <= KIND_MESH;
		end else begin
			state_q  <= state_d;
			issued_q <= issued_d;
			kind_q   <= kind_d;
		end
	end

endmodule

// ===== rtl/rbts_dp.sv =====
module rbts_dp #(
	parameter int HOTSPOT_COUNT   = 5,
	parameter int WIDE_CHANNELS   = 8,
	parameter int REGION_CHANNELS = 3,
	parameter int PAYLOAD_BUFFER  = 30
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rbts_pkg::cmd_t  cmd,
	output rbts_pkg::stat_t st,
	input  logic [1:0]      cfg_mode,
	input  logic [31:0]     cfg_seed,
	input  logic [1:0]      func,
	input  logic [31:0]     now_ms,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [1:0]      packet_kind,
	output logic [2:0]      hotspot_index,
	output logic [2:0]      channel_index,
	output logic [3:0]      spreading_factor,
	output logic [5:0]      payload_length,
	output logic [31:0]     packet_number,
	output logic            last_of_poll
);
	import rbts_pkg::*;

	localparam int IW      = (HOTSPOT_COUNT > 1) ? $clog2(HOTSPOT_COUNT) : 1;
	localparam int FW      = $clog2(PAYLOAD_BUFFER + 1);
	localparam int HS_FILL = (HS_LEN < PAYLOAD_BUFFER) ? HS_LEN : PAYLOAD_BUFFER;

	logic [1:0]   func_q;
	logic [31:0]  now_q;
	logic [31:0]  prng_q;
	logic         running_q;
	logic [1:0]   mode_q;
	logic [31:0]  cnt_q;
	logic [31:0]  t_q;
	logic [31:0]  beacon_dl_q;
	logic         burst_active_q;
	logic [2:0]   burst_left_q;
	logic [31:0]  burst_dl_q;
	logic [31:0]  uplink_dl_q;
	logic [31:0]  hs_dl_q [HOTSPOT_COUNT];
	logic [HOTSPOT_COUNT-1:0] due_q;
	logic [HOTSPOT_COUNT-1:0] due_now;
	logic [HOTSPOT_COUNT-1:0] idx_onehot;
	logic [IW-1:0] idx_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_val;
	rng_t         sel_q;
	logic [2:0]   ch_q;
	logic [3:0]   sf_q;
	logic [5:0]   len_q;
	logic         out_valid_q;

	logic [31:0]      prng_next;
	logic [REM_W-1:0] divisor;
	logic [REM_W-1:0] rem;
	logic             rem_busy;
	logic [31:0]      val;
	logic [31:0]      t_start;
	logic [31:0]      idx32;

	assign prng_next  = xorshift(prng_q);
	assign val        = rng_lo(sel_q) + 32'(rem);
	assign t_start    = now_q + START_DELAY;
	assign idx32      = 32'(idx_q);
	assign idx_onehot = HOTSPOT_COUNT'(1) << idx_q;
	assign fill_val   = (val < 32'(PAYLOAD_BUFFER)) ? val[FW-1:0] : FW'(PAYLOAD_BUFFER);

	always_comb begin
		for (int i = 0; i < HOTSPOT_COUNT; i++) begin
			due_now[i] = (now_q >= hs_dl_q[i]);
		end
	end

	always_comb begin
		unique case (cmd.sel)
			R_HS_START: divisor = REM_W'(2001);
			R_PCT:      divisor = REM_W'(100);
			R_BURSTN:   divisor = REM_W'(3);
			R_BURSTD:   divisor = REM_W'(301);
			R_BEACON:   divisor = REM_W'(60001);
			R_WIDE:     divisor = REM_W'(WIDE_CHANNELS);
			R_SF_HS:    divisor = REM_W'(3);
			R_HS_DL:    divisor = REM_W'(10001);
			R_REG:      divisor = REM_W'(REGION_CHANNELS);
			R_SF_UL:    divisor = REM_W'(6);
			R_LEN:      divisor = REM_W'(26);
			R_UL_DL:    divisor = REM_W'(20001);
			default:    divisor = REM_W'(1);
		endcase
	end

	rbts_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_RAND),
		.dividend (prng_next),
		.divisor  (divisor),
		.rem      (rem),
		.busy     (rem_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prng_q         <= SEED_RESET;
			running_q      <= 1'b0;
			mode_q         <= MODE_MESH;
			cnt_q          <= '0;
			beacon_dl_q    <= '0;
			burst_active_q <= 1'b0;
			burst_left_q   <= '0;
			burst_dl_q     <= '0;
			uplink_dl_q    <= '0;
			out_valid_q    <= 1'b0;
			idx_q          <= '0;
			fill_q         <= '0;
			due_q          <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_START: begin
					mode_q    <= cfg_mode;
					prng_q    <= cfg_seed;
					cnt_q     <= '0;
					running_q <= 1'b1;
					idx_q     <= '0;
					if (cfg_mode == MODE_MESH) begin
						beacon_dl_q    <= t_start + BEACON_FIRST;
						burst_active_q <= 1'b0;
					end
					if (cfg_mode == MODE_UPLINK) begin
						uplink_dl_q <= t_start + UPLINK_FIRST;
					end
				end
				OP_STOP:      running_q <= 1'b0;
				OP_POLL_HS: begin
					due_q <= due_now;
					idx_q <= '0;
				end
				OP_RAND:      prng_q <= prng_next;
				OP_DRAW_NEXT: begin
					prng_q <= prng_next;
					idx_q  <= idx_q + IW'(1);
				end
				OP_FILL: begin
					prng_q <= prng_next;
					fill_q <= fill_q - FW'(1);
				end
				OP_LD_FILL_MESH: fill_q <= FW'(MESH_LEN);
				OP_LD_FILL_VAL:  fill_q <= fill_val;
				OP_ST_SF:        fill_q <= FW'(HS_FILL);
				OP_EMIT: begin
					out_valid_q <= 1'b1;
					cnt_q       <= cnt_q + 32'd1;
					if (cmd.kind == KIND_RELAY) begin
						burst_left_q <= burst_left_q - 3'd1;
					end
					if (cmd.kind == KIND_HOTSPOT) begin
						due_q <= due_q & ~idx_onehot;
					end
				end
				OP_ST_BURSTN: begin
					burst_active_q <= 1'b1;
					burst_left_q   <= val[2:0];
				end
				OP_ST_BURSTD: begin
					burst_dl_q <= now_q + val;
					if (burst_left_q == 3'd0) begin
						burst_active_q <= 1'b0;
					end
				end
				OP_ST_BEACON: beacon_dl_q <= now_q + val;
				OP_ST_UL_DL:  uplink_dl_q <= now_q + val;
				OP_ST_HS_DL:  idx_q <= idx_q + IW'(1);
				OP_HS_NEXT:   idx_q <= idx_q + IW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			func_q <= func;
			now_q  <= now_ms;
		end
		if (cmd.op == OP_START) begin
			t_q <= t_start;
		end
		if (cmd.op == OP_RAND) begin
			sel_q <= cmd.sel;
		end
		if (cmd.op == OP_ST_CH) begin
			ch_q <= val[2:0];
		end
		if (cmd.op == OP_ST_SF) begin
			sf_q <= val[3:0];
		end
		if (cmd.op == OP_ST_LEN) begin
			len_q <= val[5:0];
		end
		if (cmd.op == OP_ST_HS_START) begin
			hs_dl_q[idx_q] <= t_q + idx32 * HS_STAGGER + val;
		end else if (cmd.op == OP_ST_HS_DL) begin
			hs_dl_q[idx_q] <= now_q + val;
		end
		if (cmd.op == OP_EMIT) begin
			packet_kind   <= cmd.kind;
			packet_number <= cnt_q + 32'd1;
			unique case (cmd.kind)
				KIND_MESH, KIND_RELAY: begin
					hotspot_index    <= '0;
					channel_index    <= '0;
					spreading_factor <= MESH_SF;
					payload_length   <= 6'(MESH_LEN);
					last_of_poll     <= 1'b1;
				end
				KIND_HOTSPOT: begin
					hotspot_index    <= idx32[2:0];
					channel_index    <= ch_q;
					spreading_factor <= sf_q;
					payload_length   <= 6'(HS_LEN);
					last_of_poll     <= ((due_q & ~idx_onehot) == '0);
				end
				default: begin
					hotspot_index    <= '0;
					channel_index    <= ch_q;
					spreading_factor <= sf_q;
					payload_length   <= len_q;
					last_of_poll     <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		st.func            = func_q;
		st.running         = running_q;
		st.mode            = mode_q;
		st.cfg_mode        = cfg_mode;
		st.burst_active    = burst_active_q;
		st.burst_left_zero = (burst_left_q == 3'd0);
		st.due_beacon      = (now_q >= beacon_dl_q);
		st.due_burst       = (now_q >= burst_dl_q);
		st.due_uplink      = (now_q >= uplink_dl_q);
		st.hs_cur_due      = due_q[idx_q];
		st.hs_idx_last     = (idx_q == IW'(HOTSPOT_COUNT - 1));
		st.mod_busy        = rem_busy;
		st.fill_zero       = (fill_q == '0);
		st.val_lt30        = (val < PCT_LIMIT);
		st.out_free        = !out_valid_q;
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> !out_valid_q)
		else $error("A result was loaded over one not yet transferred.");

	a_rand_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RAND |-> !rem_busy)
		else $error("A range draw was started while the remainder unit was busy.");

	a_fill_left: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_FILL |-> fill_q != '0)
		else $error("A fill draw was taken with no fill draws left.");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		burst_left_q <= 3'd5)
		else $error("The burst count left its range.");

endmodule

// ===== rtl/randomized_beacon_traffic_scheduler.sv =====
// Each ranged draw runs in the shared four-bit-per-cycle remainder unit, while payload
// fill draws only advance the PRNG state and do not use that unit.
// One item is in work at a time; the next is accepted when the sequencer is idle again.
// Reset is asynchronous and active low; it restores the seed, the mode and the beacon, burst and uplink timers.
module randomized_beacon_traffic_scheduler #(
	parameter int HOTSPOT_COUNT   = 5,
	parameter int WIDE_CHANNELS   = 8,
	parameter int REGION_CHANNELS = 3,
	parameter int PAYLOAD_BUFFER  = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  packet_kind,
	output logic [2:0]  hotspot_index,
	output logic [2:0]  channel_index,
	output logic [3:0]  spreading_factor,
	output logic [5:0]  payload_length,
	output logic [31:0] packet_number,
	output logic        last_of_poll
);
	import rbts_pkg::*;

	logic [1:0]  mode_q;
	logic [31:0] seed_q;
	cmd_t        cmd;
	stat_t       st;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? seed_q : {30'd0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MESH;
			seed_q <= SEED_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) begin
				seed_q <= pwdata;
			end else begin
				mode_q <= pwdata[1:0];
			end
		end
	end

	rbts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	rbts_dp #(
		.HOTSPOT_COUNT   (HOTSPOT_COUNT),
		.WIDE_CHANNELS   (WIDE_CHANNELS),
		.REGION_CHANNELS (REGION_CHANNELS),
		.PAYLOAD_BUFFER  (PAYLOAD_BUFFER)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.cfg_mode         (mode_q),
		.cfg_seed         (seed_q),
		.func             (func),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.packet_kind      (packet_kind),
		.hotspot_index    (hotspot_index),
		.channel_index    (channel_index),
		.spreading_factor (spreading_factor),
		.payload_length   (payload_length),
		.packet_number    (packet_number),
		.last_of_poll     (last_of_poll)
	);

endmodule
